// ===== src/srpq_pkg.sv =====
package srpq_pkg;

	localparam int unsigned DEPTH_DEF        = 16;
	localparam int unsigned KEY_BITS_DEF     = 16;
	localparam int unsigned PAYLOAD_BITS_DEF = 32;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// broadcast to every cell of the row
	typedef struct packed {
		logic insert_en;
		logic remove_en;
	} cell_cmd_t;

endpackage

// ===== src/srpq_item_if.sv =====
interface srpq_item_if import srpq_pkg::*; #(
	parameter int unsigned KEY_BITS     = KEY_BITS_DEF,
	parameter int unsigned PAYLOAD_BITS = PAYLOAD_BITS_DEF
);
	logic                    valid;
	logic                    ready;
	op_t                     operation;
	logic [KEY_BITS-1:0]     seq_key;
	logic [PAYLOAD_BITS-1:0] payload_in;

	modport source (output valid, operation, seq_key, payload_in, input ready);
	modport sink (input valid, operation, seq_key, payload_in, output ready);
endinterface

// ===== src/srpq_result_if.sv =====
interface srpq_result_if import srpq_pkg::*; #(
	parameter int unsigned PAYLOAD_BITS = PAYLOAD_BITS_DEF,
	parameter int unsigned COUNT_BITS   = $clog2(DEPTH_DEF + 1)
);
	logic                    valid;
	logic                    ready;
	logic [PAYLOAD_BITS-1:0] payload_out;
	status_t                 status;
	logic [COUNT_BITS-1:0]   entry_count;

	modport source (output valid, payload_out, status, entry_count, input ready);
	modport sink (input valid, payload_out, status, entry_count, output ready);
endinterface

// ===== src/srpq_cell.sv =====
module srpq_cell import srpq_pkg::*; #(
	parameter int unsigned KEY_BITS     = KEY_BITS_DEF,
	parameter int unsigned PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
	input  logic                    clk,
	input  cell_cmd_t               cmd,
	input  logic                    occupied,
	input  logic [KEY_BITS-1:0]     new_key,
	input  logic [PAYLOAD_BITS-1:0] new_payload,
	input  logic                    left_take,
	input  logic [KEY_BITS-1:0]     left_key,
	input  logic [PAYLOAD_BITS-1:0] left_payload,
	input  logic [KEY_BITS-1:0]     right_key,
	input  logic [PAYLOAD_BITS-1:0] right_payload,
	output logic                    take,
	output logic [KEY_BITS-1:0]     key,
	output logic [PAYLOAD_BITS-1:0] payload
);

	logic [KEY_BITS-1:0]     key_q;
	logic [PAYLOAD_BITS-1:0] payload_q;

	// new entry lands at or before this cell: free slot or key not smaller
	assign take    = !occupied || (key_q >= new_key);
	assign key     = key_q;
	assign payload = payload_q;

	always_ff @(posedge clk) begin
		if (cmd.insert_en && take) begin
			if (left_take) begin
				key_q     <= left_key;
				payload_q <= left_payload;
			end else begin
				key_q     <= new_key;
				payload_q <= new_payload;
			end
		end else if (cmd.remove_en) begin
			key_q     <= right_key;
			payload_q <= right_payload;
		end
	end

endmodule

// ===== src/sequence_reorder_priority_queue_top.sv =====
// sorted min-priority queue for putting received packets back in sequence order
//
// items channel (sink): operation, seq_key, payload_in. an insert stores the
// key and payload handle in sorted position, newest first among equal keys;
// a remove hands back the payload of the entry with the smallest key
// results channel (source): payload_out, status, entry_count, one per item.
// status is ok, empty (remove with nothing held) or full (insert dropped)
//
// entries live in a row of DEPTH cells, slot 0 at the head. every cell
// compares the broadcast key with its own and then loads from its left
// neighbour, the new entry or its right neighbour, all in one compare-and-shift step
// the result is valid the cycle after the item transfer
// throughput: one item per cycle, set by the single compare-and-shift step
// of the cell row; the result register frees as its transfer completes
// a stalled receiver holds the result and blocks further item transfers
// reset empties the queue (occupancy zero) and marks the result register empty;
// cell contents are left as they are and never read until written
module sequence_reorder_priority_queue_top import srpq_pkg::*; #(
	parameter int unsigned DEPTH        = DEPTH_DEF,
	parameter int unsigned KEY_BITS     = KEY_BITS_DEF,
	parameter int unsigned PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	srpq_item_if.sink     items,
	srpq_result_if.source results
);

	localparam int unsigned COUNT_BITS = $clog2(DEPTH + 1);

	logic [COUNT_BITS-1:0]   count_q;
	logic                    res_valid_q;
	logic [PAYLOAD_BITS-1:0] res_payload_q;
	status_t                 res_status_q;
	logic [COUNT_BITS-1:0]   res_count_q;

	logic      accept;
	logic      full;
	logic      empty;
	cell_cmd_t cmd;

	// neighbour chains across the row; take has an extra head entry
	logic [DEPTH:0]          take_chain;
	logic [KEY_BITS-1:0]     key_chain     [DEPTH];
	logic [PAYLOAD_BITS-1:0] payload_chain [DEPTH];

	// the result register parts the two sides: refill as it drains
	assign items.ready = !res_valid_q || results.ready;
	assign accept      = items.valid && items.ready;

	assign full  = (count_q == COUNT_BITS'(DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		cmd.insert_en = accept && (items.operation == OP_INSERT) && !full;
		cmd.remove_en = accept && (items.operation == OP_REMOVE) && !empty;
	end

	// no cell to the left of the head
	assign take_chain[0] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam int unsigned RIGHT = (i + 1 < DEPTH) ? i + 1 : i;

		logic occupied;

		assign occupied = (COUNT_BITS'(i) < count_q);

		srpq_cell #(
			.KEY_BITS     (KEY_BITS),
			.PAYLOAD_BITS (PAYLOAD_BITS)
		) u_cell (
			.clk           (clk),
			.cmd           (cmd),
			.occupied      (occupied),
			.new_key       (items.seq_key),
			.new_payload   (items.payload_in),
			.left_take     (take_chain[i]),
			.left_key      (key_chain[(i > 0) ? i - 1 : 0]),
			.left_payload  (payload_chain[(i > 0) ? i - 1 : 0]),
			.right_key     (key_chain[RIGHT]),
			.right_payload (payload_chain[RIGHT]),
			.take          (take_chain[i+1]),
			.key           (key_chain[i]),
			.payload       (payload_chain[i])
		);
	end

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.insert_en) begin
			count_q <= count_q + COUNT_BITS'(1);
		end else if (cmd.remove_en) begin
			count_q <= count_q - COUNT_BITS'(1);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (items.operation == OP_INSERT) begin
				res_payload_q <= '0;
				if (full) begin
					res_status_q <= ST_FULL;
					res_count_q  <= count_q;
				end else begin
					res_status_q <= ST_OK;
					res_count_q  <= count_q + COUNT_BITS'(1);
				end
			end else begin
				if (empty) begin
					res_payload_q <= '0;
					res_status_q  <= ST_EMPTY;
					res_count_q   <= count_q;
				end else begin
					res_payload_q <= payload_chain[0];
					res_status_q  <= ST_OK;
					res_count_q   <= count_q - COUNT_BITS'(1);
				end
			end
		end
	end

	assign results.valid       = res_valid_q;
	assign results.payload_out = res_payload_q;
	assign results.status      = res_status_q;
	assign results.entry_count = res_count_q;

endmodule

// ===== tb/sv/tb.sv =====
module tb;
	import srpq_pkg::*;

	localparam int unsigned COUNT_BITS = $clog2(DEPTH_DEF + 1);
	// longest run of cycles with no transfer on either channel before giving up
	localparam int unsigned STALL_LIMIT = 3000;
	// cycles allowed after the last result for anything stray to turn up
	localparam int unsigned DRAIN_CYCLES = 8;

	typedef logic [KEY_BITS_DEF-1:0]     key_t;
	typedef logic [PAYLOAD_BITS_DEF-1:0] payload_t;

	// one awaited result transfer
	typedef struct {
		payload_t              payload;
		status_t               status;
		logic [COUNT_BITS-1:0] count;
	} queue_result_t;

	logic clk;
	logic arst_n;

	srpq_item_if   item_bus ();
	srpq_result_if result_bus ();

	sequence_reorder_priority_queue_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (item_bus),
		.results (result_bus)
	);

	// shadow copy of the sorted row, slot 0 leaves first
	key_t     held_keys [DEPTH_DEF];
	payload_t held_payloads [DEPTH_DEF];
	int       held_count;

	queue_result_t awaited_results [$];

	int fail_count;
	int idle_cycles;

	// idling knobs, changed between phases by the test tasks
	int send_idle_pct;
	int recv_stall_pct;
	// long receiver hold-off, counted down by the receiver process itself
	int hold_off_cycles;

	// clock: period of 12 time units
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// works out the result of one accepted item and moves the shadow row on
	task automatic reorder_predict(input op_t op, input key_t key, input payload_t pay);
		queue_result_t r;
		int            pos;
		int            i;
		r.payload = '0;
		r.status  = ST_OK;
		if (op == OP_INSERT) begin
			if (held_count >= DEPTH_DEF) begin
				// dropped, row left alone
				r.status = ST_FULL;
			end else begin
				// new entry goes ahead of every key greater than or equal to it,
				// so the newest of equal keys leaves first
				pos = 0;
				while (pos < held_count && held_keys[pos] < key)
					pos++;
				for (i = held_count; i > pos; i--) begin
					held_keys[i]     = held_keys[i-1];
					held_payloads[i] = held_payloads[i-1];
				end
				held_keys[pos]     = key;
				held_payloads[pos] = pay;
				held_count++;
			end
		end else begin
			if (held_count == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.payload = held_payloads[0];
				for (i = 1; i < held_count; i++) begin
					held_keys[i-1]     = held_keys[i];
					held_payloads[i-1] = held_payloads[i];
				end
				held_count--;
			end
		end
		r.count = held_count[COUNT_BITS-1:0];
		awaited_results.push_back(r);
	endtask

	// offers one item, with random gaps before it, and waits for its transfer;
	// valid only ever changes at a falling edge, once per edge at most
	task automatic send_item(input op_t op, input key_t key, input payload_t pay);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			@(negedge clk);
			item_bus.valid <= 1'b0;
		end
		@(negedge clk);
		item_bus.valid      <= 1'b1;
		item_bus.operation  <= op;
		item_bus.seq_key    <= key;
		item_bus.payload_in <= pay;
		do
			@(posedge clk);
		while (!(item_bus.valid && item_bus.ready));
		reorder_predict(op, key, pay);
	endtask

	// keys drawn so that equal keys, the extremes and the full range all turn up
	function automatic key_t pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return key_t'($urandom_range(0, 15));
		else if (r < 50)
			return ($urandom_range(0, 1) != 0) ? '1 : '0;
		else
			return key_t'($urandom_range(0, 65535));
	endfunction

	function automatic payload_t pick_payload();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		else if (r < 10)
			return '1;
		else
			return payload_t'($urandom);
	endfunction

	// receiver: ready driven at the falling edge, either held off for a long
	// stretch or stalled at random
	initial begin
		result_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_cycles > 0) begin
				result_bus.ready <= 1'b0;
				hold_off_cycles--;
			end else begin
				result_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// checker: every result transfer is matched against the oldest awaited one
	always @(posedge clk) begin
		queue_result_t exp;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: result with nothing awaited, got payload %h status %0d count %0d",
					$time, result_bus.payload_out, result_bus.status, result_bus.entry_count);
				fail_count++;
			end else begin
				exp = awaited_results.pop_front();
				if (result_bus.payload_out !== exp.payload) begin
					$display("%0t: payload_out mismatch, expected %h, got %h",
						$time, exp.payload, result_bus.payload_out);
					fail_count++;
				end
				if (result_bus.status !== exp.status) begin
					$display("%0t: status mismatch, expected %0d, got %0d",
						$time, exp.status, result_bus.status);
					fail_count++;
				end
				if (result_bus.entry_count !== exp.count) begin
					$display("%0t: entry_count mismatch, expected %0d, got %0d",
						$time, exp.count, result_bus.entry_count);
					fail_count++;
				end
			end
		end
	end

	// watchdog: too long without any transfer means the block has hung
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, idle_cycles);
				$display("Verification failed");
				$finish;
			end
		end
	end

	// empty queue on remove, both key extremes, equal keys leaving newest first
	task automatic test_corner_cases();
		send_item(OP_REMOVE, '0, '1);
		send_item(OP_INSERT, '0, '0);
		send_item(OP_INSERT, '1, '1);
		send_item(OP_INSERT, 16'h1234, 32'h0000_000a);
		send_item(OP_INSERT, 16'h1234, 32'h0000_000b);
		send_item(OP_INSERT, 16'h1234, 32'h0000_000c);
		send_item(OP_INSERT, 16'h5555, 32'h5555_5555);
		send_item(OP_INSERT, 16'haaaa, 32'haaaa_aaaa);
		repeat (7)
			send_item(OP_REMOVE, pick_key(), pick_payload());
		send_item(OP_REMOVE, '1, '0);
	endtask

	// fill the row to the brim, try one more, then drain it to empty
	task automatic test_full_queue();
		int i;
		for (i = 0; i < DEPTH_DEF; i++)
			send_item(OP_INSERT, key_t'(DEPTH_DEF - i), pick_payload());
		// full: smallest key of all must still be dropped
		send_item(OP_INSERT, '0, '1);
		send_item(OP_REMOVE, '0, '0);
		send_item(OP_INSERT, '1, 32'hdead_beef);
		send_item(OP_INSERT, '0, '1);
		for (i = 0; i < DEPTH_DEF; i++)
			send_item(OP_REMOVE, pick_key(), pick_payload());
		send_item(OP_REMOVE, '0, '0);
	endtask

	// random traffic; the insert share drifts so the fill level sweeps between
	// empty and full over and over
	task automatic test_random(input int n, input int idle_pct, input int stall_pct);
		int k;
		int ins_pct;
		op_t op;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		ins_pct        = 50;
		for (k = 0; k < n; k++) begin
			if (k % 24 == 0) begin
				case ($urandom_range(0, 2))
					0: ins_pct = 15;
					1: ins_pct = 50;
					default: ins_pct = 85;
				endcase
			end
			op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_REMOVE;
			send_item(op, pick_key(), pick_payload());
		end
	endtask

	// receiver holds off for a long stretch while items keep coming, so the
	// result register stays full and the item channel has to stall
	task automatic test_backpressure();
		int k;
		op_t op;
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		hold_off_cycles = 150;
		for (k = 0; k < 40; k++) begin
			op = ($urandom_range(0, 99) < 70) ? OP_INSERT : OP_REMOVE;
			send_item(op, pick_key(), pick_payload());
		end
	endtask

	initial begin
		held_count      = 0;
		fail_count      = 0;
		idle_cycles     = 0;
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		hold_off_cycles = 0;

		item_bus.valid      = 1'b0;
		item_bus.operation  = OP_INSERT;
		item_bus.seq_key    = '0;
		item_bus.payload_in = '0;

		// reset asserted from the start, released away from the rising edge
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_corner_cases();
		test_full_queue();
		test_random(420, 0, 0);
		test_random(420, 50, 0);
		test_random(420, 0, 50);
		test_backpressure();
		test_random(420, 13, 13);

		@(negedge clk);
		item_bus.valid <= 1'b0;

		// wait for every awaited result, the watchdog bounds this
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
